FILE: rtl/bclpd_pkg.sv
// ----------------------------------------------------------------------------
// bclpd_pkg
// Shared types, codes and reset values for the button click / long-press
// detector.
// ----------------------------------------------------------------------------
package bclpd_pkg;

  localparam int COUNT_WIDTH_DEF = 8;
  localparam int CFG_WIDTH       = 8;
  localparam int DATA_WIDTH      = 32;
  localparam int ADDR_WIDTH      = 5;

  // register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_TRIGGER_LEVEL  = 3'd0,
    REG_INITIAL_LEVEL  = 3'd1,
    REG_DEBOUNCE_TICKS = 3'd2,
    REG_LONG_TICKS     = 3'd3,
    REG_REPEAT_TICKS   = 3'd4
  } reg_idx_t;

  localparam logic                 RST_TRIGGER_LEVEL  = 1'b0;
  localparam logic                 RST_INITIAL_LEVEL  = 1'b1;
  localparam logic [CFG_WIDTH-1:0] RST_DEBOUNCE_TICKS = 8'd2;
  localparam logic [CFG_WIDTH-1:0] RST_LONG_TICKS     = 8'd50;
  localparam logic [CFG_WIDTH-1:0] RST_REPEAT_TICKS   = 8'd2;

  typedef struct packed {
    logic                 trigger_level;
    logic                 initial_level;
    logic [CFG_WIDTH-1:0] debounce_ticks;
    logic [CFG_WIDTH-1:0] long_ticks;
    logic [CFG_WIDTH-1:0] repeat_ticks;
  } cfg_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_DOWN = 3'b010,
    PH_UP   = 3'b100
  } phase_t;

  localparam logic [1:0] PHASE_CODE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_CODE_DOWN = 2'd1;
  localparam logic [1:0] PHASE_CODE_UP   = 2'd2;

  typedef enum logic [1:0] {
    TRG_NONE = 2'd0,
    TRG_DOWN = 2'd1,
    TRG_LONG = 2'd2
  } trig_t;

  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_CLICK     = 2'd1,
    EV_LONG      = 2'd2,
    EV_LONG_FREE = 2'd3
  } ev_t;

  function automatic logic [1:0] phase_code(input phase_t ph);
    logic [1:0] code;
    case (ph)
      PH_IDLE: code = PHASE_CODE_IDLE;
      PH_DOWN: code = PHASE_CODE_DOWN;
      PH_UP:   code = PHASE_CODE_UP;
      default: code = PHASE_CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

FILE: rtl/bclpd_regs.sv
// ----------------------------------------------------------------------------
// bclpd_regs
// APB register file holding the detector configuration. Flags a write of the
// initial level so the debounced level can be reloaded.
// ----------------------------------------------------------------------------
module bclpd_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bclpd_pkg::ADDR_WIDTH-1:0]    paddr,
  input  logic [bclpd_pkg::DATA_WIDTH-1:0]    pwdata,
  output logic [bclpd_pkg::DATA_WIDTH-1:0]    prdata,
  output logic                                pready,
  output bclpd_pkg::cfg_t                     cfg,
  output logic                                init_load
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[4:2];

  assign init_load = wr_en && (idx == bclpd_pkg::REG_INITIAL_LEVEL);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_level  <= bclpd_pkg::RST_TRIGGER_LEVEL;
      cfg.initial_level  <= bclpd_pkg::RST_INITIAL_LEVEL;
      cfg.debounce_ticks <= bclpd_pkg::RST_DEBOUNCE_TICKS;
      cfg.long_ticks     <= bclpd_pkg::RST_LONG_TICKS;
      cfg.repeat_ticks   <= bclpd_pkg::RST_REPEAT_TICKS;
    end else if (wr_en) begin
      case (idx)
        bclpd_pkg::REG_TRIGGER_LEVEL:  cfg.trigger_level  <= pwdata[0];
        bclpd_pkg::REG_INITIAL_LEVEL:  cfg.initial_level  <= pwdata[0];
        bclpd_pkg::REG_DEBOUNCE_TICKS:
          cfg.debounce_ticks <= pwdata[bclpd_pkg::CFG_WIDTH-1:0];
        bclpd_pkg::REG_LONG_TICKS:
          cfg.long_ticks     <= pwdata[bclpd_pkg::CFG_WIDTH-1:0];
        bclpd_pkg::REG_REPEAT_TICKS:
          cfg.repeat_ticks   <= pwdata[bclpd_pkg::CFG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      bclpd_pkg::REG_TRIGGER_LEVEL:  prdata[0] = cfg.trigger_level;
      bclpd_pkg::REG_INITIAL_LEVEL:  prdata[0] = cfg.initial_level;
      bclpd_pkg::REG_DEBOUNCE_TICKS:
        prdata[bclpd_pkg::CFG_WIDTH-1:0] = cfg.debounce_ticks;
      bclpd_pkg::REG_LONG_TICKS:
        prdata[bclpd_pkg::CFG_WIDTH-1:0] = cfg.long_ticks;
      bclpd_pkg::REG_REPEAT_TICKS:
        prdata[bclpd_pkg::CFG_WIDTH-1:0] = cfg.repeat_ticks;
      default: prdata = '0;
    endcase
  end

endmodule

FILE: rtl/bclpd_step.sv
// ----------------------------------------------------------------------------
// bclpd_step
// Next-state logic for one tick: debounce, phase tracking, hold and repeat
// counting, event selection.
// ----------------------------------------------------------------------------
module bclpd_step #(
  parameter int COUNT_WIDTH = bclpd_pkg::COUNT_WIDTH_DEF
) (
  input  bclpd_pkg::cfg_t          cfg,
  input  logic                     lvl,
  input  logic                     deb,
  input  logic [COUNT_WIDTH-1:0]   chg_cnt,
  input  bclpd_pkg::phase_t        phase,
  input  bclpd_pkg::trig_t         trig,
  input  logic [COUNT_WIDTH-1:0]   hold_cnt,
  input  logic [COUNT_WIDTH-1:0]   rep_cnt,
  output logic                     deb_next,
  output logic [COUNT_WIDTH-1:0]   chg_cnt_next,
  output bclpd_pkg::phase_t        phase_next,
  output bclpd_pkg::trig_t         trig_next,
  output logic [COUNT_WIDTH-1:0]   hold_cnt_next,
  output logic [COUNT_WIDTH-1:0]   rep_cnt_next,
  output bclpd_pkg::ev_t           ev
);

  logic                   diff;
  logic                   chg_ok;
  logic [COUNT_WIDTH-1:0] chg_inc;
  logic [COUNT_WIDTH-1:0] hold_inc;
  logic [COUNT_WIDTH-1:0] rep_inc;
  logic [COUNT_WIDTH-1:0] long_ext;
  bclpd_pkg::phase_t      phase_mid;

  assign diff     = (lvl != deb);
  assign chg_inc  = chg_cnt + COUNT_WIDTH'(1);
  assign chg_ok   = diff && (chg_inc >= COUNT_WIDTH'(cfg.debounce_ticks));
  assign hold_inc = hold_cnt + COUNT_WIDTH'(1);
  assign rep_inc  = rep_cnt + COUNT_WIDTH'(1);
  assign long_ext = COUNT_WIDTH'(cfg.long_ticks);

  always_comb begin
    deb_next     = chg_ok ? lvl : deb;
    chg_cnt_next = diff ? (chg_ok ? '0 : chg_inc) : chg_cnt;

    // up is sticky against further accepted changes
    phase_mid = phase;
    if (chg_ok) begin
      case (phase)
        bclpd_pkg::PH_IDLE: phase_mid = bclpd_pkg::PH_DOWN;
        bclpd_pkg::PH_DOWN: phase_mid = bclpd_pkg::PH_UP;
        default:            phase_mid = phase;
      endcase
    end

    phase_next    = phase_mid;
    trig_next     = trig;
    hold_cnt_next = hold_cnt;
    rep_cnt_next  = rep_cnt;
    ev            = bclpd_pkg::EV_NONE;

    case (phase_mid)
      bclpd_pkg::PH_DOWN: begin
        if (deb_next == cfg.trigger_level) begin
          if (trig != bclpd_pkg::TRG_LONG) trig_next = bclpd_pkg::TRG_DOWN;
          hold_cnt_next = hold_inc;
          if (hold_inc >= long_ext) begin
            rep_cnt_next = rep_inc;
            if (rep_inc >= COUNT_WIDTH'(cfg.repeat_ticks)) begin
              rep_cnt_next = '0;
              trig_next    = bclpd_pkg::TRG_LONG;
              ev           = bclpd_pkg::EV_LONG;
            end
            // saturated hold count falls back to the threshold
            if (&hold_inc) hold_cnt_next = long_ext;
          end
        end
      end
      bclpd_pkg::PH_UP: begin
        if (trig == bclpd_pkg::TRG_DOWN) begin
          hold_cnt_next = '0;
          ev            = bclpd_pkg::EV_CLICK;
          phase_next    = bclpd_pkg::PH_IDLE;
        end else if (trig == bclpd_pkg::TRG_LONG) begin
          hold_cnt_next = '0;
          ev            = bclpd_pkg::EV_LONG_FREE;
          phase_next    = bclpd_pkg::PH_IDLE;
          trig_next     = bclpd_pkg::TRG_DOWN;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/button_click_long_press_detector.sv
// ----------------------------------------------------------------------------
// button_click_long_press_detector
// Debounces a sampled button level and reports clicks, repeating long-press
// events and long-press releases, one result item per input item.
// ----------------------------------------------------------------------------
//  channel  | handshake                       | payload
//  ---------+---------------------------------+------------------------------------
//  input    | in_valid / in_ready             | raw_level
//  output   | out_valid / out_ready           | event_res, press_phase,
//           |                                 | trigger_kind, stable_level
//  config   | APB psel/penable/pwrite/pready  | paddr, pwdata, prdata
//
//  One item per cycle while the output is not stalled; its result appears in the output register the cycle
//  after acceptance. The state update for a tick is one pass of next-state
//  logic into the state registers.
//  in_ready is high whenever the output register is empty or being drained.
//  Synchronous reset loads register defaults and clears the detector state;
//  the debounced level starts at the initial level.
// ----------------------------------------------------------------------------
module button_click_long_press_detector #(
  parameter int COUNT_WIDTH = bclpd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bclpd_pkg::ADDR_WIDTH-1:0]  paddr,
  input  logic [bclpd_pkg::DATA_WIDTH-1:0]  pwdata,
  output logic [bclpd_pkg::DATA_WIDTH-1:0]  prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              raw_level,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        event_res,
  output logic [1:0]                        press_phase,
  output logic [1:0]                        trigger_kind,
  output logic                              stable_level
);

  bclpd_pkg::cfg_t        cfg;
  logic                   init_load;
  logic                   accept;

  logic                   deb;
  logic [COUNT_WIDTH-1:0] chg_cnt;
  bclpd_pkg::phase_t      phase;
  bclpd_pkg::trig_t       trig;
  logic [COUNT_WIDTH-1:0] hold_cnt;
  logic [COUNT_WIDTH-1:0] rep_cnt;

  logic                   deb_next;
  logic [COUNT_WIDTH-1:0] chg_cnt_next;
  bclpd_pkg::phase_t      phase_next;
  bclpd_pkg::trig_t       trig_next;
  logic [COUNT_WIDTH-1:0] hold_cnt_next;
  logic [COUNT_WIDTH-1:0] rep_cnt_next;
  bclpd_pkg::ev_t         ev;

  bclpd_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg       (cfg),
    .init_load (init_load)
  );

  bclpd_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .cfg           (cfg),
    .lvl           (raw_level),
    .deb           (deb),
    .chg_cnt       (chg_cnt),
    .phase         (phase),
    .trig          (trig),
    .hold_cnt      (hold_cnt),
    .rep_cnt       (rep_cnt),
    .deb_next      (deb_next),
    .chg_cnt_next  (chg_cnt_next),
    .phase_next    (phase_next),
    .trig_next     (trig_next),
    .hold_cnt_next (hold_cnt_next),
    .rep_cnt_next  (rep_cnt_next),
    .ev            (ev)
  );

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      deb      <= bclpd_pkg::RST_INITIAL_LEVEL;
      chg_cnt  <= '0;
      phase    <= bclpd_pkg::PH_IDLE;
      trig     <= bclpd_pkg::TRG_NONE;
      hold_cnt <= '0;
      rep_cnt  <= '0;
    end else if (init_load) begin
      deb <= pwdata[0];
    end else if (accept) begin
      deb      <= deb_next;
      chg_cnt  <= chg_cnt_next;
      phase    <= phase_next;
      trig     <= trig_next;
      hold_cnt <= hold_cnt_next;
      rep_cnt  <= rep_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result payload, loaded with each accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      event_res    <= ev;
      press_phase  <= bclpd_pkg::phase_code(phase_next);
      trigger_kind <= trig_next;
      stable_level <= deb_next;
    end
  end

endmodule

FILE: rtl/bclpd_checker.sv
// ----------------------------------------------------------------------------
// bclpd_checker
// Port-level checks on the detector's result items, bound to the top level.
// ----------------------------------------------------------------------------
module bclpd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] event_res,
  input logic [1:0] press_phase,
  input logic [1:0] trigger_kind
);

  // a stalled result must not vanish
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // each accepted item yields a result next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("no result item after accepted item");

  a_codes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> press_phase != 2'd3 && trigger_kind != 2'd3)
    else $error("phase or trigger code out of range");

  // click and long release both end in idle with a down trigger latched
  a_release: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == bclpd_pkg::EV_CLICK || event_res == bclpd_pkg::EV_LONG_FREE)
      |-> press_phase == bclpd_pkg::PHASE_CODE_IDLE && trigger_kind == bclpd_pkg::TRG_DOWN)
    else $error("release event with inconsistent phase or trigger");

  a_long: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == bclpd_pkg::EV_LONG
      |-> press_phase == bclpd_pkg::PHASE_CODE_DOWN && trigger_kind == bclpd_pkg::TRG_LONG)
    else $error("long press event outside held phase");

endmodule

bind button_click_long_press_detector bclpd_checker u_bclpd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .event_res    (event_res),
  .press_phase  (press_phase),
  .trigger_kind (trigger_kind)
);
